FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: sv/obtt_pkg.sv
// Package for the overlap box track table: status codes, field widths and
// the sequencer states. No dependencies.
`default_nettype none
package obtt_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 3;

  localparam logic [PCT_W-1:0] PCT_RESET = 7'd70;
  localparam logic [ID_W-1:0]  ID_MAX    = 16'hFFFF;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STAT_W-1:0] ST_RENEWED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADSLOT = 3'd4;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_SPAN  = 9'b000000100,
    S_PROD  = 9'b000001000,
    S_CMP   = 9'b000010000,
    S_SH_RD = 9'b000100000,
    S_SH_WR = 9'b001000000,
    S_PUT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage
`default_nettype wire

FILE: sv/overlap_box_track_table.sv
// Overlap box track table: ordered table of tracked boxes in one memory.
// Depends on obtt_pkg and assert_macros.svh.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries an item with an
// operation, a box and a slot; one output channel (out_valid_o / out_stall_i)
// returns exactly one result item per input item. An item moves when valid is
// high and stall is low. cfg_we_i writes overlap_percent (reset value 70).
// A detection reads the stored boxes one after another from a memory with
// one read port with registered data and one write port; each entry goes
// through read, span and area multiply, threshold multiply and compare. A
// match then closes the gap with one read and one write per later entry.
// One item is in work at a time; the next one is taken when the sequencer is
// back in idle, even if the previous result still sits in the output register.
// A stalled output holds the result; a finished item waits for the output
// register to free up. Reset empties the table, sets the next id to 1 and
// needs no clearing pass: entries past the fill count are never read.
`default_nettype none
`include "assert_macros.svh"
module overlap_box_track_table #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [obtt_pkg::PCT_W-1:0]    cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           operation_i,
  input  wire  [COORD_BITS-1:0]         box_x_i,
  input  wire  [COORD_BITS-1:0]         box_y_i,
  input  wire  [COORD_BITS-1:0]         box_width_i,
  input  wire  [COORD_BITS-1:0]         box_height_i,
  input  wire  [obtt_pkg::SLOT_W-1:0]   slot_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [obtt_pkg::STAT_W-1:0]   status_o,
  output logic [obtt_pkg::ID_W-1:0]     track_id_o,
  output logic [obtt_pkg::ID_W-1:0]     track_score_o,
  output logic [obtt_pkg::SLOT_W-1:0]   position_o,
  output logic [obtt_pkg::COUNT_W-1:0]  entry_count_o
);
  import obtt_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned XW   = CW + SLOT_W + COUNT_W;
  localparam int unsigned IPW  = 2 * CB + 2;
  localparam int unsigned PW   = 2 * CB + 9;
  localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

  typedef struct packed {
    logic [CB-1:0]   x;
    logic [CB-1:0]   y;
    logic [CB-1:0]   w;
    logic [CB-1:0]   h;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] score;
  } entry_t;

  // Control and working registers
  state_e              state_q, state_d;
  logic [PCT_W-1:0]    pct_q;
  logic [CW-1:0]       count_q;
  logic [ID_W-1:0]     fresh_q;
  logic [CW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic                op_q;
  logic [CB-1:0]       bx_q, by_q, bw_q, bh_q;
  logic [ID_W-1:0]     ent_id_q, ent_score_q;
  logic [IPW-1:0]      inter_q;
  logic [2*CB-1:0]     area_q;
  logic [PW-1:0]       lhs_q, rhs_q;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [ID_W-1:0]     rid_q, rid_d, rscore_q, rscore_d;
  logic                out_valid_q;
  logic [STAT_W-1:0]   o_status_q;
  logic [ID_W-1:0]     o_id_q, o_score_q;
  logic [SLOT_W-1:0]   o_pos_q;
  logic [COUNT_W-1:0]  o_count_q;

  // Memory signals
  entry_t              mem [ENTRIES];
  entry_t              rdata_q;
  logic                re, we;
  logic [IW-1:0]       raddr, waddr;
  entry_t              wdata;

  logic                accept;
  logic [XW-1:0]       slot_x, count_x;
  logic                slot_ok;
  logic [CW-1:0]       idx_inc;
  logic                load_out;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign slot_x  = XW'(slot_i);
  assign count_x = XW'(count_q);
  assign slot_ok = slot_x < count_x;
  assign idx_inc = idx_q + CW'(1);

  // Overlap of the stored box with the new box along each axis
  logic [CB:0]       sx_lo, sx_hi, sy_lo, sy_hi, ae, be, ov_x, ov_y;
  always_comb begin
    sx_lo = ({1'b0, rdata_q.x} > {1'b0, bx_q}) ? {1'b0, rdata_q.x} : {1'b0, bx_q};
    ae    = {1'b0, rdata_q.x} + {1'b0, rdata_q.w};
    be    = {1'b0, bx_q} + {1'b0, bw_q};
    sx_hi = (ae < be) ? ae : be;
    ov_x  = (sx_hi > sx_lo) ? (sx_hi - sx_lo) : '0;
    sy_lo = ({1'b0, rdata_q.y} > {1'b0, by_q}) ? {1'b0, rdata_q.y} : {1'b0, by_q};
    sy_hi = (({1'b0, rdata_q.y} + {1'b0, rdata_q.h}) < ({1'b0, by_q} + {1'b0, bh_q}))
            ? ({1'b0, rdata_q.y} + {1'b0, rdata_q.h}) : ({1'b0, by_q} + {1'b0, bh_q});
    ov_y  = (sy_hi > sy_lo) ? (sy_hi - sy_lo) : '0;
  end

  // Memory: one read port with registered data, one write port
  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Memory access per state
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx_q[IW-1:0];
    waddr = idx_q[IW-1:0];
    wdata = rdata_q;
    case (state_q)
      S_RD: begin
        re = 1'b1;
      end
      S_SH_RD: begin
        re    = 1'b1;
        raddr = idx_inc[IW-1:0];
      end
      S_SH_WR: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = (status_q != ST_FULL) && (status_q != ST_BADSLOT);
        waddr = pos_q;
        wdata = '{x: bx_q, y: by_q, w: bw_q, h: bh_q, id: rid_q, score: rscore_q};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    status_d = status_q;
    rid_d    = rid_q;
    rscore_d = rscore_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rid_d    = '0;
          rscore_d = '0;
          pos_d    = '0;
          if (operation_i) begin
            if (slot_ok) begin
              status_d = ST_UPDATED;
              idx_d    = slot_x[CW-1:0];
              pos_d    = slot_x[IW-1:0];
              state_d  = S_RD;
            end else begin
              status_d = ST_BADSLOT;
              state_d  = S_DONE;
            end
          end else begin
            idx_d = '0;
            if (count_q == '0) begin
              status_d = ST_NEW;
              rid_d    = fresh_q;
              rscore_d = ID_W'(1);
              state_d  = S_PUT;
            end else begin
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_d = S_SPAN;
      end
      S_SPAN: begin
        if (op_q) begin
          rid_d    = rdata_q.id;
          rscore_d = rdata_q.score;
          state_d  = S_PUT;
        end else begin
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (lhs_q > rhs_q) begin
          status_d = ST_RENEWED;
          rid_d    = ent_id_q;
          rscore_d = (ent_score_q == ID_MAX) ? ID_MAX : ent_score_q + ID_W'(1);
          pos_d    = IW'(count_q - CW'(1));
          state_d  = (idx_inc < count_q) ? S_SH_RD : S_PUT;
        end else if (idx_inc < count_q) begin
          idx_d   = idx_inc;
          state_d = S_RD;
        end else if (count_q == FULL_COUNT) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          status_d = ST_NEW;
          rid_d    = fresh_q;
          rscore_d = ID_W'(1);
          pos_d    = count_q[IW-1:0];
          state_d  = S_PUT;
        end
      end
      S_SH_RD: begin
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        idx_d   = idx_inc;
        state_d = ((idx_inc + CW'(1)) < count_q) ? S_SH_RD : S_PUT;
      end
      S_PUT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pct_q       <= PCT_RESET;
      count_q     <= '0;
      fresh_q     <= ID_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pct_q <= cfg_wdata_i;
      end
      if (state_q == S_PUT && status_q == ST_NEW) begin
        count_q <= count_q + CW'(1);
        fresh_q <= fresh_q + ID_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    rid_q    <= rid_d;
    rscore_q <= rscore_d;
    if (accept) begin
      op_q <= operation_i;
      bx_q <= box_x_i;
      by_q <= box_y_i;
      bw_q <= box_width_i;
      bh_q <= box_height_i;
    end
    if (state_q == S_SPAN) begin
      ent_id_q    <= rdata_q.id;
      ent_score_q <= rdata_q.score;
      inter_q     <= IPW'(ov_x) * IPW'(ov_y);
      area_q      <= (2*CB)'(rdata_q.w) * (2*CB)'(rdata_q.h);
    end
    if (state_q == S_PROD) begin
      lhs_q <= PW'(inter_q) * PW'(100);
      rhs_q <= PW'(pct_q) * PW'(area_q);
    end
    if (load_out) begin
      o_status_q <= status_q;
      o_id_q     <= rid_q;
      o_score_q  <= rscore_q;
      o_pos_q    <= SLOT_W'(XW'(pos_q));
      o_count_q  <= COUNT_W'(count_x);
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign track_id_o    = o_id_q;
  assign track_score_o = o_score_q;
  assign position_o    = o_pos_q;
  assign entry_count_o = o_count_q;

  // Checks
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= FULL_COUNT)
  `ASSERT_CLK(a_count_step, clk_i, rst_ni, (state_q == S_PUT && status_q == ST_NEW) |=> count_q == $past(count_q) + CW'(1))
  `ASSERT_CLK(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  `ASSERT_CLK(a_full_no_insert, clk_i, rst_ni, (state_q == S_PUT && status_q == ST_NEW) |-> count_q < FULL_COUNT)

endmodule
`default_nettype wire
